>>> design/horw_pkg.sv
`timescale 1ns / 1ps

package horw_pkg;

    // record size and character constants
    localparam int RecordBytesDefault = 16;
    localparam logic [7:0] CharSemi    = 8'h3B;
    localparam logic [7:0] CharNewline = 8'h0A;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharSeven   = 8'h37;

    localparam int StepW = 4;

    // input opcodes
    localparam logic OpData  = 1'b0;
    localparam logic OpFlush = 1'b1;

    // source of the character sent in a step
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_SEMI,
        SEL_CNT,
        SEL_ADDR,
        SEL_DATA,
        SEL_SUM,
        SEL_NL
    } t_sel;

    // how the step counter moves on
    typedef enum logic [1:0] {
        J_NEXT,
        J_WAIT,
        J_LOOP,
        J_DONE
    } t_jmp;

    typedef struct packed {
        t_sel             sel;
        logic [1:0]       nib;
        logic             last;
        t_jmp             jmp;
        logic [StepW-1:0] target;
    } t_ctrl;

    // program steps that code reads by name
    localparam logic [StepW-1:0] StepIdle  = 4'd0;
    localparam logic [StepW-1:0] StepFirst = 4'd1;
    localparam logic [StepW-1:0] StepData  = 4'd8;

    // ascii upper-case hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v > 4'd9) begin
            c = CharSeven + {4'd0, v};
        end else begin
            c = CharZero + {4'd0, v};
        end
        return c;
    endfunction

    // control store: ';' CC AAAA (DD)* SSSS newline
    function automatic t_ctrl ctrl_rom(input logic [StepW-1:0] step);
        t_ctrl w;
        unique case (step)
            4'd0:    w = '{SEL_NONE, 2'd0, 1'b0, J_WAIT, StepIdle};
            4'd1:    w = '{SEL_SEMI, 2'd0, 1'b0, J_NEXT, StepIdle};
            4'd2:    w = '{SEL_CNT,  2'd1, 1'b0, J_NEXT, StepIdle};
            4'd3:    w = '{SEL_CNT,  2'd0, 1'b0, J_NEXT, StepIdle};
            4'd4:    w = '{SEL_ADDR, 2'd3, 1'b0, J_NEXT, StepIdle};
            4'd5:    w = '{SEL_ADDR, 2'd2, 1'b0, J_NEXT, StepIdle};
            4'd6:    w = '{SEL_ADDR, 2'd1, 1'b0, J_NEXT, StepIdle};
            4'd7:    w = '{SEL_ADDR, 2'd0, 1'b0, J_NEXT, StepIdle};
            4'd8:    w = '{SEL_DATA, 2'd1, 1'b0, J_NEXT, StepIdle};
            4'd9:    w = '{SEL_DATA, 2'd0, 1'b0, J_LOOP, StepData};
            4'd10:   w = '{SEL_SUM,  2'd3, 1'b0, J_NEXT, StepIdle};
            4'd11:   w = '{SEL_SUM,  2'd2, 1'b0, J_NEXT, StepIdle};
            4'd12:   w = '{SEL_SUM,  2'd1, 1'b0, J_NEXT, StepIdle};
            4'd13:   w = '{SEL_SUM,  2'd0, 1'b0, J_NEXT, StepIdle};
            4'd14:   w = '{SEL_NL,   2'd0, 1'b1, J_DONE, StepIdle};
            default: w = '{SEL_NONE, 2'd0, 1'b0, J_WAIT, StepIdle};
        endcase
        return w;
    endfunction

endpackage

>>> design/horw_if.sv
`timescale 1ns / 1ps

// input item channel: opcode, address, data byte
interface horw_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] addr;
    logic [7:0]  data_byte;

    modport source (output valid, output opcode, output addr, output data_byte, input ready);
    modport sink   (input valid, input opcode, input addr, input data_byte, output ready);
endinterface

// output item channel: one record character
interface horw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);
endinterface

>>> design/hex_object_record_writer_unit.sv
`timescale 1ns / 1ps

// Hex object record writer. Gathers (address, byte) items of consecutive addresses
// into records ";CCAAAA<DD..>SSSS\n" of up to RECORD_BYTES bytes and sends them one
// character per output item. A data byte that opens or extends a record is stored
// in the record and gives no output. An item that closes a record (address break,
// full record, or flush) starts a small microcode sequencer that sends the record
// one character per cycle through the single output register, unless back-pressure
// on the output holds it. The input is ready only while the sequencer waits at its
// idle step.
module hex_object_record_writer_unit #(
    parameter int RECORD_BYTES = horw_pkg::RecordBytesDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    horw_in_if.sink    i_in,
    horw_out_if.source o_out
);

    localparam int IW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int CW = $clog2(RECORD_BYTES + 1);
    localparam int SW = horw_pkg::StepW;

    // sequencer and record state
    logic [SW-1:0] r_step, n_step;
    logic [CW-1:0] r_fill;
    logic [IW-1:0] r_idx, n_idx;
    logic [15:0]   r_start;
    logic [16:0]   r_next;
    logic [15:0]   r_sum;
    logic [7:0]    r_rd;

    // item held while its record break is sent
    logic          r_pend_data;
    logic [15:0]   r_pend_addr;
    logic [7:0]    r_pend_byte;

    // output register
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_last;

    logic [7:0]    mem [RECORD_BYTES];

    horw_pkg::t_ctrl ctrl;
    logic          in_acc;
    logic          out_free;
    logic          need_emit;
    logic          emit;
    logic          idx_end;
    logic          apply;
    logic          apply_fresh;
    logic [15:0]   apply_addr;
    logic [7:0]    apply_byte;
    logic          done;
    logic [15:0]   chk;
    logic [15:0]   field;
    logic [3:0]    nibble;
    logic [7:0]    chr;

    assign ctrl     = horw_pkg::ctrl_rom(r_step);
    assign i_in.ready = (ctrl.jmp == horw_pkg::J_WAIT);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign chk      = r_sum + 16'(r_fill);
    assign idx_end  = (CW'(r_idx) + CW'(1)) == r_fill;

    // record break test for the arriving item
    assign need_emit = (r_fill != '0) &&
                       ((i_in.opcode == horw_pkg::OpFlush) ||
                        ({1'b0, i_in.addr} != r_next) ||
                        (r_fill >= CW'(RECORD_BYTES)));

    // step sequencing and data byte placement
    always_comb begin
        n_step      = r_step;
        n_idx       = r_idx;
        done        = 1'b0;
        apply       = 1'b0;
        apply_fresh = 1'b0;
        apply_addr  = i_in.addr;
        apply_byte  = i_in.data_byte;
        unique case (ctrl.jmp)
            horw_pkg::J_WAIT: begin
                n_idx = '0;
                if (in_acc && need_emit) begin
                    n_step = horw_pkg::StepFirst;
                end
                apply       = in_acc && !need_emit && (i_in.opcode == horw_pkg::OpData);
                apply_fresh = (r_fill == '0);
            end
            horw_pkg::J_NEXT: begin
                if (out_free) begin
                    n_step = r_step + SW'(1);
                end
            end
            horw_pkg::J_LOOP: begin
                if (out_free) begin
                    if (idx_end) begin
                        n_step = r_step + SW'(1);
                    end else begin
                        n_step = ctrl.target;
                        n_idx  = r_idx + IW'(1);
                    end
                end
            end
            horw_pkg::J_DONE: begin
                if (out_free) begin
                    n_step      = ctrl.target;
                    done        = 1'b1;
                    apply       = r_pend_data;
                    apply_fresh = 1'b1;
                    apply_addr  = r_pend_addr;
                    apply_byte  = r_pend_byte;
                end
            end
            default: n_step = r_step;
        endcase
    end

    // character select
    always_comb begin
        unique case (ctrl.sel)
            horw_pkg::SEL_CNT:  field = {8'd0, 8'(r_fill)};
            horw_pkg::SEL_ADDR: field = r_start;
            horw_pkg::SEL_DATA: field = {8'd0, r_rd};
            horw_pkg::SEL_SUM:  field = chk;
            default:            field = 16'd0;
        endcase
        unique case (ctrl.nib)
            2'd0:    nibble = field[3:0];
            2'd1:    nibble = field[7:4];
            2'd2:    nibble = field[11:8];
            2'd3:    nibble = field[15:12];
            default: nibble = field[3:0];
        endcase
        unique case (ctrl.sel)
            horw_pkg::SEL_SEMI: chr = horw_pkg::CharSemi;
            horw_pkg::SEL_NL:   chr = horw_pkg::CharNewline;
            default:            chr = horw_pkg::hex_char(nibble);
        endcase
    end

    assign emit = (ctrl.sel != horw_pkg::SEL_NONE) && out_free;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= horw_pkg::StepIdle;
            r_idx       <= '0;
            r_fill      <= '0;
            r_start     <= '0;
            r_next      <= '0;
            r_sum       <= '0;
            r_pend_data <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_idx  <= n_idx;
            if (in_acc) begin
                r_pend_data <= (i_in.opcode == horw_pkg::OpData);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (apply) begin
                r_next <= {1'b0, apply_addr} + 17'd1;
                if (apply_fresh) begin
                    r_start <= apply_addr;
                    r_sum   <= 16'(apply_addr[15:8]) + 16'(apply_addr[7:0]) +
                               16'(apply_byte);
                    r_fill  <= CW'(1);
                end else begin
                    r_sum  <= r_sum + 16'(apply_byte);
                    r_fill <= r_fill + CW'(1);
                end
            end else if (done) begin
                r_fill <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pend_addr <= i_in.addr;
            r_pend_byte <= i_in.data_byte;
        end
        if (emit) begin
            r_out_char <= chr;
            r_out_last <= ctrl.last;
        end
    end

    // record byte store
    always_ff @(posedge i_clk) begin
        if (apply) begin
            mem[apply_fresh ? IW'(0) : r_fill[IW-1:0]] <= apply_byte;
        end
        r_rd <= mem[n_idx];
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_out_char;
    assign o_out.last     = r_out_last;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(RECORD_BYTES))
        else $error("record fill above capacity");

    a_emit_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != horw_pkg::StepIdle) |-> (r_fill != '0))
        else $error("record sent with no open record");

    a_last_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_char == horw_pkg::CharNewline)))
        else $error("last flag not on record newline");

    a_empty_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.opcode == horw_pkg::OpFlush) && (r_fill == '0))
            |=> (r_step == horw_pkg::StepIdle))
        else $error("flush of empty record started a record");
`endif

endmodule

>>> tb/hex_object_record_writer_unit_tb.sv
`timescale 1ns / 1ps

module hex_object_record_writer_unit_tb;

    localparam int RecBytes   = horw_pkg::RecordBytesDefault;
    localparam int ItemTarget = 300;
    localparam int QuietTail  = 50;
    localparam int HoldLen    = 400;

    // upper-case hex digits, digit 0 in the top byte
    localparam logic [127:0] HexDigits = "0123456789ABCDEF";

    // one expected record character
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_rec_char;

    logic i_clk;
    logic i_rst_n;

    horw_in_if  in_ch ();
    horw_out_if out_ch ();

    hex_object_record_writer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // open record as the block should hold it
    logic [7:0]  rec_buf [RecBytes];
    int unsigned rec_fill = 0;
    logic [15:0] rec_start = '0;
    logic [16:0] rec_next = '0;
    logic [15:0] rec_sum = '0;
    t_rec_char   record_text_q [$];

    int fail_count      = 0;
    int items_sent      = 0;
    int chars_checked   = 0;
    int records_checked = 0;
    int send_gap_pct    = 0;
    int recv_stall_pct  = 0;
    int hold_cycles     = 0;

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // queue one character of record text
    function automatic void push_text_char(input logic [7:0] c, input logic is_last);
        record_text_q.push_back('{c, is_last});
    endfunction

    // queue a value as a run of hex digits, most significant first
    function automatic void push_hex(input logic [15:0] v, input int ndig);
        logic [3:0] nib;
        for (int d = ndig - 1; d >= 0; d--) begin
            nib = v[4*d +: 4];
            push_text_char(HexDigits[(15 - nib) * 8 +: 8], 1'b0);
        end
    endfunction

    // queue the full text of the open record and close it
    function automatic void close_record();
        logic [15:0] total;
        total = rec_sum + 16'(rec_fill);
        push_text_char(horw_pkg::CharSemi, 1'b0);
        push_hex(16'(rec_fill), 2);
        push_hex(rec_start, 4);
        for (int i = 0; i < rec_fill; i++) begin
            push_hex({8'd0, rec_buf[i]}, 2);
        end
        push_hex(total, 4);
        push_text_char(horw_pkg::CharNewline, 1'b1);
        rec_fill = 0;
    endfunction

    // expected record characters for one accepted input item
    function automatic void predict_record_text(input logic op, input logic [15:0] a,
                                                input logic [7:0] b);
        if (op == horw_pkg::OpFlush) begin
            if (rec_fill != 0) begin
                close_record();
            end
        end else begin
            if (rec_fill != 0 && ({1'b0, a} != rec_next || rec_fill >= RecBytes)) begin
                close_record();
            end
            if (rec_fill == 0) begin
                rec_start = a;
                rec_sum   = 16'(a[15:8]) + 16'(a[7:0]);
            end
            rec_buf[rec_fill] = b;
            rec_fill++;
            rec_sum  = rec_sum + 16'(b);
            rec_next = {1'b0, a} + 17'd1;
        end
    endfunction

    // offer one item, wait until it is taken, then maybe idle
    task automatic send_item(input logic op, input logic [15:0] a, input logic [7:0] b);
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.addr      <= a;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_record_text(op, a, b);
        items_sent++;
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // flush with random don't-care payload
    task automatic send_flush();
        send_item(horw_pkg::OpFlush, 16'($urandom), 8'($urandom));
    endtask

    // stop offering until the block has sent everything expected
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (record_text_q.size() != 0) @(posedge i_clk);
    endtask

    // compare each accepted character with the oldest expected one
    always @(posedge i_clk) begin : char_check
        t_rec_char want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (record_text_q.size() == 0) begin
                $display("%0t: unexpected item: expected none, actual char %h last %b",
                         $time, out_ch.char_out, out_ch.last);
                fail_count++;
            end else begin
                want = record_text_q.pop_front();
                if (out_ch.char_out !== want.ch) begin
                    $display("%0t: char_out mismatch: expected %h, actual %h",
                             $time, want.ch, out_ch.char_out);
                    fail_count++;
                end
                if (out_ch.last !== want.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, out_ch.last);
                    fail_count++;
                end
                chars_checked++;
                if (want.last) begin
                    records_checked++;
                end
            end
        end
    end

    // receiver: random stall bursts, or a long hold-off on request
    initial begin : recv_side
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                out_ch.ready <= 1'b1;
            end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // flush with nothing open gives no text
    task automatic test_empty_flush();
        send_flush();
    endtask

    // two-byte record with the lowest address and extreme bytes
    task automatic test_short_record();
        send_item(horw_pkg::OpData, 16'h0000, 8'h00);
        send_item(horw_pkg::OpData, 16'h0001, 8'hFF);
        send_flush();
    endtask

    // address wraps from the top, so the next byte starts a new record
    task automatic test_address_wrap();
        send_item(horw_pkg::OpData, 16'hFFFF, 8'hA5);
        send_item(horw_pkg::OpData, 16'h0000, 8'h5A);
    endtask

    // a full record, then one more contiguous byte that opens the next
    task automatic test_full_record();
        for (int i = 0; i <= RecBytes; i++) begin
            send_item(horw_pkg::OpData, 16'h1234 + 16'(i),
                      (i < RecBytes) ? 8'(i * 8'h11) : 8'h80);
        end
        send_flush();
    endtask

    // output held off long enough that the block stops taking input
    task automatic test_output_hold();
        logic [15:0] a;
        hold_cycles = HoldLen;
        repeat (8) begin
            a = 16'($urandom);
            repeat (3) begin
                send_item(horw_pkg::OpData, a, 8'($urandom));
                a++;
            end
        end
        send_flush();
    endtask

    // sender waits for all text before it goes on
    task automatic test_drain_pause();
        logic [15:0] a;
        a = 16'($urandom);
        repeat (5) begin
            send_item(horw_pkg::OpData, a, 8'($urandom));
            a++;
        end
        send_flush();
        pause_until_drained();
        repeat (3) begin
            send_item(horw_pkg::OpData, a, 8'($urandom));
            a++;
        end
        send_flush();
    endtask

    // mostly contiguous runs of random content, with flushes and stray bytes
    task automatic test_random_runs();
        int          kind;
        int          run_len;
        int          seg_start;
        logic [15:0] a;
        seg_start = items_sent;
        while (items_sent < ItemTarget) begin
            if (items_sent >= ItemTarget - QuietTail) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end else if (items_sent - seg_start >= 40) begin
                seg_start      = items_sent;
                send_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
                recv_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                      : $urandom_range(1, RecBytes);
                a = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 20))
                                                : 16'($urandom);
                repeat (run_len) begin
                    send_item(horw_pkg::OpData, a, 8'($urandom));
                    a++;
                end
            end else if (kind < 88) begin
                send_flush();
            end else begin
                send_item(horw_pkg::OpData, 16'($urandom), 8'($urandom));
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = horw_pkg::OpData;
        in_ch.addr      = '0;
        in_ch.data_byte = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_pct   = 20;
        recv_stall_pct = 20;
        test_empty_flush();
        test_short_record();
        test_address_wrap();
        test_full_record();
        test_output_hold();
        test_drain_pause();
        test_random_runs();

        // let the last record drain, then watch for stray output
        pause_until_drained();
        repeat (60) @(posedge i_clk);

        $display("covered %0d input items: flushes, address breaks, wrap and full records",
                 items_sent);
        $display("checked %0d characters in %0d records", chars_checked, records_checked);
        if (fail_count == 0 && record_text_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("%0t: timeout with %0d characters outstanding", $time, record_text_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
